/* rtl/core/mvavg_pkg.sv */
package mvavg_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 7;

  // defaults
  localparam int          DEF_MAX_WINDOW = 64;
  localparam logic [6:0]  WIN_LEN_RST    = 7'd15;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MIN,
    ST_MAX,
    ST_SUB,
    ST_ADD,
    ST_DIV,
    ST_FINISH
  } state_e;

endpackage

/* rtl/core/mvavg_if.sv */
interface mvavg_in_if;
  import mvavg_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                start_series;

  modport source (output valid, output sample, output start_series, input ready);
  modport sink   (input valid, input sample, input start_series, output ready);
endinterface

interface mvavg_out_if;
  import mvavg_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] average;
  logic                average_valid;
  logic [SAMPLE_W-1:0] series_min;
  logic [SAMPLE_W-1:0] series_max;

  modport source (output valid, output average, output average_valid,
                  output series_min, output series_max, input ready);
  modport sink   (input valid, input average, input average_valid,
                  input series_min, input series_max, output ready);
endinterface

/* rtl/core/moving_average_min_max.sv */
// moving average with running min/max, one beat in, one beat out
// average by restoring division of the SUM_W-bit sum (SUM_W = 32 + clog2(MAX_WINDOW),
//   38 by default), one quotient bit per cycle on the shared adder; no division while
//   the window fills; a new beat is taken only after the result of the last one is
//   loaded into the output register
// reset: async active low, clears window, min/max, sets window_len to 15; ring not cleared
module moving_average_min_max #(
  parameter int MAX_WINDOW = mvavg_pkg::DEF_MAX_WINDOW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mvavg_pkg::CFG_W-1:0] cfg_wdata_i,
  mvavg_in_if.sink                   in_ch_i,
  mvavg_out_if.source                out_ch_o
);
  import mvavg_pkg::*;

  localparam int SLOT_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W     = SAMPLE_W + SLOT_W;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [CFG_W-1:0]    window_len_q;
  logic [SUM_W-1:0]    sum_q;
  logic [CNT_W-1:0]    fill_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [SAMPLE_W-1:0] min_q;
  logic [SAMPLE_W-1:0] max_q;
  logic                seeded_q;

  // per-beat working registers
  logic [SAMPLE_W-1:0]  smp_q;       // latched sample
  logic [CNT_W-1:0]     len_q;       // effective window length for this beat
  logic [SAMPLE_W-1:0]  old_q;       // ring read data, oldest sample
  logic                 full_q;      // window full after this beat
  logic [SUM_W-1:0]     dq_q;        // dividend shifting out, quotient shifting in
  logic [CNT_W-1:0]     rem_q;       // partial remainder
  logic [DIV_CNT_W-1:0] div_cnt_q;

  // output register
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_avg_q;
  logic                out_avg_vld_q;
  logic [SAMPLE_W-1:0] out_min_q;
  logic [SAMPLE_W-1:0] out_max_q;

  // sample ring
  logic [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];

  // ---------------------------------------------------------------------------
  // combinational helpers
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]  len_eff;
  logic [SLOT_W-1:0] slot_eff;
  logic [CNT_W-1:0]  slot_inc;
  logic [CNT_W-1:0]  fill_next;
  logic [CNT_W:0]    partial;
  logic              in_hs;
  logic              out_load;

  // window_len of zero acts as one, above MAX_WINDOW it saturates
  always_comb begin
    if (window_len_q == '0) begin
      len_eff = CNT_W'(1);
    end else if (int'(window_len_q) > MAX_WINDOW) begin
      len_eff = CNT_W'(MAX_WINDOW);
    end else begin
      len_eff = CNT_W'(window_len_q);
    end
  end

  // slot wraps when the window shrank since the last write
  assign slot_eff  = (CNT_W'(slot_q) >= len_q) ? '0 : slot_q;
  assign slot_inc  = CNT_W'(slot_q) + CNT_W'(1);
  assign fill_next = (fill_q < len_q) ? fill_q + CNT_W'(1) : fill_q;
  // next divider trial value: remainder with the next dividend bit shifted in
  assign partial   = {rem_q, dq_q[SUM_W-1]};

  assign in_hs = in_ch_i.valid & in_ch_i.ready;

  // ---------------------------------------------------------------------------
  // shared adder / subtractor
  // ---------------------------------------------------------------------------
  alu_op_e          alu_op;
  logic [SUM_W-1:0] alu_a;
  logic [SUM_W-1:0] alu_b;
  logic [SUM_W-1:0] alu_y;
  logic             alu_borrow;

  mvavg_alu #(
    .W (SUM_W)
  ) u_alu (
    .op_i     (alu_op),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .y_o      (alu_y),
    .borrow_o (alu_borrow)
  );

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_hs) state_d = ST_READ;
      ST_READ:   state_d = ST_MIN;
      ST_MIN:    state_d = ST_MAX;
      ST_MAX:    state_d = ST_SUB;
      ST_SUB:    state_d = ST_ADD;
      ST_ADD:    state_d = (fill_next >= len_q) ? ST_DIV : ST_FINISH;
      ST_DIV:    if (div_cnt_q == '0) state_d = ST_FINISH;
      ST_FINISH: if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: outputs, adder operand steering
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ch_i.ready = 1'b0;
    out_load      = 1'b0;
    alu_op        = ALU_ADD;
    alu_a         = sum_q;
    alu_b         = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ch_i.ready = 1'b1;
      end
      ST_MIN: begin
        // borrow means sample < min
        alu_op = ALU_SUB;
        alu_a  = SUM_W'(smp_q);
        alu_b  = SUM_W'(min_q);
      end
      ST_MAX: begin
        // borrow means max < sample
        alu_op = ALU_SUB;
        alu_a  = SUM_W'(max_q);
        alu_b  = SUM_W'(smp_q);
      end
      ST_SUB: begin
        alu_op = ALU_SUB;
        alu_a  = sum_q;
        alu_b  = SUM_W'(old_q);
      end
      ST_ADD: begin
        alu_op = ALU_ADD;
        alu_a  = sum_q;
        alu_b  = SUM_W'(smp_q);
      end
      ST_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = SUM_W'(partial);
        alu_b  = SUM_W'(len_q);
      end
      ST_FINISH: begin
        out_load = ~out_valid_q | out_ch_o.ready;
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // control and running state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      window_len_q <= WIN_LEN_RST;
      sum_q        <= '0;
      fill_q       <= '0;
      slot_q       <= '0;
      min_q        <= '0;
      max_q        <= '0;
      seeded_q     <= 1'b0;
      full_q       <= 1'b0;
      div_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        // new window length restarts window fill, series min/max kept
        window_len_q <= cfg_wdata_i;
        sum_q        <= '0;
        fill_q       <= '0;
        slot_q       <= '0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_hs && in_ch_i.start_series) begin
            sum_q    <= '0;
            fill_q   <= '0;
            slot_q   <= '0;
            seeded_q <= 1'b0;
          end
        end
        ST_READ: begin
          slot_q <= slot_eff;
        end
        ST_MIN: begin
          if (!seeded_q || alu_borrow) min_q <= smp_q;
        end
        ST_MAX: begin
          if (!seeded_q || alu_borrow) max_q <= smp_q;
          seeded_q <= 1'b1;
        end
        ST_SUB: begin
          // oldest sample leaves the sum once the window is full
          if (fill_q >= len_q) sum_q <= alu_y;
        end
        ST_ADD: begin
          sum_q     <= alu_y;
          fill_q    <= fill_next;
          slot_q    <= (slot_inc >= len_q) ? '0 : slot_inc[SLOT_W-1:0];
          full_q    <= (fill_next >= len_q);
          div_cnt_q <= DIV_CNT_W'(SUM_W - 1);
        end
        ST_DIV: begin
          if (div_cnt_q != '0) div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
        end
        default: begin
        end
      endcase

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers, no reset
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      smp_q <= in_ch_i.sample;
      len_q <= len_eff;
    end
    if (state_q == ST_ADD) begin
      dq_q  <= alu_y;
      rem_q <= '0;
    end
    if (state_q == ST_DIV) begin
      // restoring division, one quotient bit per cycle
      if (alu_borrow) begin
        rem_q <= partial[CNT_W-1:0];
        dq_q  <= {dq_q[SUM_W-2:0], 1'b0};
      end else begin
        rem_q <= alu_y[CNT_W-1:0];
        dq_q  <= {dq_q[SUM_W-2:0], 1'b1};
      end
    end
    if (out_load) begin
      out_avg_q     <= full_q ? dq_q[SAMPLE_W-1:0] : '0;
      out_avg_vld_q <= full_q;
      out_min_q     <= min_q;
      out_max_q     <= max_q;
    end
  end

  // sample ring, read in READ, overwritten in SUB
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      old_q <= ring_mem[slot_eff];
    end
    if (state_q == ST_SUB) begin
      ring_mem[slot_q] <= smp_q;
    end
  end

  assign out_ch_o.valid         = out_valid_q;
  assign out_ch_o.average       = out_avg_q;
  assign out_ch_o.average_valid = out_avg_vld_q;
  assign out_ch_o.series_min    = out_min_q;
  assign out_ch_o.series_max    = out_max_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill_q) <= MAX_WINDOW)
    else $error("fill count beyond ring depth");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch_o.valid |-> (out_ch_o.series_min <= out_ch_o.series_max))
    else $error("series min above series max");

  a_avg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch_o.valid && !out_ch_o.average_valid) |-> (out_ch_o.average == '0))
    else $error("average nonzero while window not full");

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch_i.valid && in_ch_i.ready) |=> (state_q == ST_READ))
    else $error("accepted beat did not start sequence");

endmodule

/* rtl/core/mvavg_alu.sv */
module mvavg_alu #(
  parameter int W = 38
) (
  input  mvavg_pkg::alu_op_e op_i,
  input  logic [W-1:0]       a_i,
  input  logic [W-1:0]       b_i,
  output logic [W-1:0]       y_o,
  output logic               borrow_o
);
  import mvavg_pkg::*;

  logic [W:0] sum_ext;
  logic       is_sub;

  assign is_sub  = (op_i == ALU_SUB);
  // a - b as a + ~b + 1; carry out low means a < b
  assign sum_ext = {1'b0, a_i} + {1'b0, (is_sub ? ~b_i : b_i)} + {{W{1'b0}}, is_sub};
  assign y_o      = sum_ext[W-1:0];
  assign borrow_o = is_sub & ~sum_ext[W];

endmodule
